[hdl/dsq_pkg.sv]
// Shared types, codes and helper function of the four phase dose sequencer.
package dsq_pkg;

    // Most results that one request can produce (abort, start, complete).
    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_A    = 3'd1,
        PH_B    = 3'd2,
        PH_UP   = 3'd3,
        PH_DOWN = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_STARTED  = 2'd1,
        EV_ABORTED  = 2'd2,
        EV_COMPLETE = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] now_time;
        logic [31:0] dur_nutrient_a;
        logic [31:0] dur_nutrient_b;
        logic [31:0] dur_ph_up;
        logic [31:0] dur_ph_down;
    } request_t;

    typedef struct packed {
        logic [3:0]  valve_mask;
        event_t      event_code;
        logic [31:0] dosed_a_ms;
        logic [31:0] dosed_b_ms;
        logic        busy_res;
    } result_t;

    // Valve that is open in a given phase; idle and unused codes close all.
    function automatic logic [3:0] mask_of(phase_t ph);
        logic [3:0] m;
        case (ph)
            PH_A:    m = 4'b0001;
            PH_B:    m = 4'b0010;
            PH_UP:   m = 4'b0100;
            PH_DOWN: m = 4'b1000;
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

[hdl/dsq_core.sv]
// Sequencer state and the single pass that turns one request into its results.
module dsq_core
    import dsq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  request_t                  req,
    output result_t [MAX_RES-1:0]     res,
    output logic [CNT_W-1:0]          res_cnt
);

    phase_t      phase_reg,  phase_next;
    logic [31:0] start_reg,  start_next;
    logic [31:0] dur_a_reg,  dur_a_next;
    logic [31:0] dur_b_reg,  dur_b_next;
    logic [31:0] dur_up_reg, dur_up_next;
    logic [31:0] dur_dn_reg, dur_dn_next;

    logic        active;
    logic [31:0] cur_dur;
    logic [31:0] elapsed;
    logic [3:0]  nz_new;
    logic [3:0]  nz_held;
    phase_t      ph;
    logic        done;
    logic [CNT_W-1:0] n;

    // First phase at or after index 'from' (0 means nutrient A) with a
    // non-zero duration; idle when none is left.
    function automatic phase_t next_phase(logic [3:0] nz, logic [2:0] from);
        phase_t r;
        r = PH_IDLE;
        for (int i = 3; i >= 0; i--) begin
            if (nz[i] && (3'(i) >= from)) begin
                r = phase_t'(3'(i + 1));
            end
        end
        return r;
    endfunction

    assign active  = (phase_reg >= PH_A) && (phase_reg <= PH_DOWN);
    assign elapsed = req.now_time - start_reg;
    assign nz_new  = {req.dur_ph_down != 32'd0, req.dur_ph_up != 32'd0,
                      req.dur_nutrient_b != 32'd0, req.dur_nutrient_a != 32'd0};
    assign nz_held = {dur_dn_reg != 32'd0, dur_up_reg != 32'd0,
                      dur_b_reg != 32'd0, dur_a_reg != 32'd0};

    // Duration of the phase that is running now.
    always_comb begin
        case (phase_reg)
            PH_A:    cur_dur = dur_a_reg;
            PH_B:    cur_dur = dur_b_reg;
            PH_UP:   cur_dur = dur_up_reg;
            PH_DOWN: cur_dur = dur_dn_reg;
            default: cur_dur = 32'd0;
        endcase
    end

    // Next state and the list of results for the request.
    always_comb begin
        phase_next  = phase_reg;
        start_next  = start_reg;
        dur_a_next  = dur_a_reg;
        dur_b_next  = dur_b_reg;
        dur_up_next = dur_up_reg;
        dur_dn_next = dur_dn_reg;
        res         = '0;
        n           = '0;
        ph          = phase_reg;
        done        = 1'b0;
        case (req.operation)
            OP_START: begin
                if (active) begin
                    res[0].event_code = EV_ABORTED;
                    n = 2'd1;
                end
                dur_a_next  = req.dur_nutrient_a;
                dur_b_next  = req.dur_nutrient_b;
                dur_up_next = req.dur_ph_up;
                dur_dn_next = req.dur_ph_down;
                start_next  = req.now_time;
                ph          = next_phase(nz_new, 3'd0);
                phase_next  = ph;
                res[n].valve_mask = mask_of(ph);
                res[n].event_code = EV_STARTED;
                res[n].busy_res   = (ph != PH_IDLE);
                n = n + 2'd1;
                // All four durations zero: the run completes at once.
                if (ph == PH_IDLE) begin
                    res[n].event_code = EV_COMPLETE;
                    res[n].dosed_a_ms = req.dur_nutrient_a;
                    res[n].dosed_b_ms = req.dur_nutrient_b;
                    n = n + 2'd1;
                end
            end
            OP_STOP: begin
                phase_next        = PH_IDLE;
                res[0].event_code = active ? EV_ABORTED : EV_NONE;
                n                 = 2'd1;
            end
            OP_TICK: begin
                if (active && (elapsed >= cur_dur)) begin
                    start_next = req.now_time;
                    ph         = next_phase(nz_held, phase_reg);
                    phase_next = ph;
                    done       = (ph == PH_IDLE);
                end
                res[0].valve_mask = mask_of(ph);
                res[0].event_code = done ? EV_COMPLETE : EV_NONE;
                res[0].dosed_a_ms = done ? dur_a_reg : 32'd0;
                res[0].dosed_b_ms = done ? dur_b_reg : 32'd0;
                res[0].busy_res   = (mask_of(ph) != 4'd0);
                n                 = 2'd1;
            end
            default: begin
                res[0].valve_mask = mask_of(phase_reg);
                res[0].event_code = EV_NONE;
                res[0].busy_res   = active;
                n                 = 2'd1;
            end
        endcase
        res_cnt = n;
    end

    // Phase register is control state and is cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            start_reg  <= '0;
            dur_a_reg  <= '0;
            dur_b_reg  <= '0;
            dur_up_reg <= '0;
            dur_dn_reg <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            dur_a_reg  <= dur_a_next;
            dur_b_reg  <= dur_b_next;
            dur_up_reg <= dur_up_next;
            dur_dn_reg <= dur_dn_next;
        end
    end

endmodule

[hdl/dsq_out.sv]
// Result register bank that hands out the results of one request in order.
module dsq_out
    import dsq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load_req,
    input  result_t [MAX_RES-1:0] res,
    input  logic [CNT_W-1:0]      res_cnt,
    output logic                  take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    result_t [MAX_RES-1:0] q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  pop;
    logic                  load_ok;

    assign pop     = m_tvalid && m_tready;
    // New results may enter once the bank is empty or its final beat leaves.
    assign load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign take    = load_req && load_ok;

    // Result count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (take) begin
            cnt_reg <= res_cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result payload shifts toward slot zero as beats leave.
    always_ff @(posedge aclk) begin
        if (take) begin
            q_reg <= res;
        end else if (pop) begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_tuser  = q_reg[0].event_code;
    assign m_tdata  = {3'b000, q_reg[0].busy_res, q_reg[0].dosed_b_ms,
                       q_reg[0].dosed_a_ms, q_reg[0].valve_mask};

endmodule

[hdl/four_phase_dose_sequencer_unit.sv]
// Top level of the four phase dose sequencer: input register, core and result bank.
//
// Sequences four valves (nutrient A, nutrient B, pH up, pH down) from start, stop
// and tick requests. Each request gives one to three results: a start over an
// active run gives aborted then started, and a start with all durations zero
// gives started then complete. A request is registered on entry, its results are
// all formed combinationally from that register, and they are loaded into the
// result bank once it can take them. The result bank sends one result per cycle
// while m_tready is high. Ticks and stops give one result each and a start up to
// three. A new request is taken in the cycle the final result of the previous
// one leaves, or at once when the bank is empty.
module four_phase_dose_sequencer_unit
    import dsq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_time [31:0], dur_nutrient_a [63:32], dur_nutrient_b [95:64],
    // dur_ph_up [127:96], dur_ph_down [159:128]
    input  logic [159:0] s_tdata,
    // operation [1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // valve_mask [3:0], dosed_a_ms [35:4], dosed_b_ms [67:36], busy_res [68],
    // zero fill [71:69]
    output logic [71:0]  m_tdata,
    // event_code [1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic                  in_valid_reg;
    request_t              in_reg;
    logic                  take;
    result_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]      res_cnt;

    assign s_tready = !in_valid_reg || take;

    // Input request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.operation      <= op_t'(s_tuser);
            in_reg.now_time       <= s_tdata[31:0];
            in_reg.dur_nutrient_a <= s_tdata[63:32];
            in_reg.dur_nutrient_b <= s_tdata[95:64];
            in_reg.dur_ph_up      <= s_tdata[127:96];
            in_reg.dur_ph_down    <= s_tdata[159:128];
        end
    end

    dsq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (take),
        .req     (in_reg),
        .res     (res),
        .res_cnt (res_cnt)
    );

    dsq_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_req (in_valid_reg),
        .res      (res),
        .res_cnt  (res_cnt),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    // At most one valve is ever open.
    a_one_valve: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[3:0]))
        else $error("more than one valve open");

    // The busy flag agrees with the valve state.
    a_busy_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[68] == (m_tdata[3:0] != 4'd0)))
        else $error("busy flag disagrees with valve mask");

    // A completed run leaves all valves closed.
    a_complete_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_COMPLETE)) |-> (m_tdata[3:0] == 4'd0))
        else $error("valve open on complete event");

    // A request moved into the result bank is offered in the next cycle.
    a_take_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_tvalid)
        else $error("taken request produced no result");
`endif

endmodule
